FILE: hw/rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mme_pkg;

  // fixed field widths of the channels
  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned IDX_BITS  = 3;
  localparam int unsigned DIM_BITS  = 4;
  localparam int unsigned REG_BITS  = 2;
  localparam int unsigned FRAC_BITS = 16;

  // configuration register indexes
  localparam logic [REG_BITS-1:0] CFG_A_ROWS     = 2'd0;
  localparam logic [REG_BITS-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [REG_BITS-1:0] CFG_B_COLS     = 2'd2;
  // unused index: writes are ignored
  localparam logic [REG_BITS-1:0] CFG_SPARE      = 2'd3;

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [DIM_BITS-1:0] dim_t;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;
    logic wr_right;
    idx_t wr_row;
    idx_t wr_col;
    logic rd_en;
    idx_t rd_i;
    idx_t rd_r;
    idx_t rd_j;
    logic mac_first;
    logic mac_last;
    logic emit;
    idx_t emit_row;
    idx_t emit_col;
    logic emit_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/mme_if.sv
// Channel interfaces of the matrix multiply engine: element input, product
// output and configuration write. Depends on mme_pkg.
interface mme_elem_if;
  logic                             valid;
  logic                             ready;
  logic signed [mme_pkg::ELEM_BITS-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface mme_prod_if;
  logic                             valid;
  logic                             ready;
  logic [mme_pkg::IDX_BITS-1:0]     out_row;
  logic [mme_pkg::IDX_BITS-1:0]     out_col;
  logic signed [mme_pkg::ELEM_BITS-1:0] product_value;
  logic                             overflow;
  logic                             last;

  modport source (output valid, output out_row, output out_col, output product_value,
                  output overflow, output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product_value,
                  input overflow, input last, output ready);
endinterface

interface mme_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mme_pkg::REG_BITS-1:0] reg_index;
  logic [mme_pkg::DIM_BITS-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hw/rtl/mme_ctrl.sv
// Sequencer of the matrix multiply engine: size registers, load counters
// and the MAC / emit state machine. Depends on mme_pkg.
module mme_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mme_pkg::REG_BITS-1:0] cfg_index,
  input  logic [mme_pkg::DIM_BITS-1:0] cfg_data,
  input  mme_pkg::dp_sts_t             sts,
  output mme_pkg::dp_cmd_t             cmd
);

  localparam mme_pkg::dim_t DIM_MAX = mme_pkg::DIM_BITS'(MAX_DIM);

  function automatic mme_pkg::dim_t clamp_dim(input mme_pkg::dim_t v);
    mme_pkg::dim_t res;
    res = v;
    if (v == '0) res = mme_pkg::DIM_BITS'(1);
    else if (v > DIM_MAX) res = DIM_MAX;
    return res;
  endfunction

  mme_pkg::state_t state_r, state_nxt;
  mme_pkg::dim_t   a_rows_r, a_rows_nxt;
  mme_pkg::dim_t   inner_r, inner_nxt;
  mme_pkg::dim_t   b_cols_r, b_cols_nxt;
  logic            ph_b_r, ph_b_nxt;
  mme_pkg::idx_t   ld_row_r, ld_row_nxt;
  mme_pkg::idx_t   ld_col_r, ld_col_nxt;
  mme_pkg::idx_t   i_r, i_nxt;
  mme_pkg::idx_t   j_r, j_nxt;
  mme_pkg::idx_t   r_r, r_nxt;

  mme_pkg::dim_t   m1, k1, n1, row_lim, col_lim;
  logic            i_end, j_end, r_end;
  logic            cfg_wr;

  assign m1 = a_rows_r - mme_pkg::DIM_BITS'(1);
  assign k1 = inner_r - mme_pkg::DIM_BITS'(1);
  assign n1 = b_cols_r - mme_pkg::DIM_BITS'(1);
  // A is m x k, B is k x n
  assign row_lim = ph_b_r ? k1 : m1;
  assign col_lim = ph_b_r ? n1 : k1;
  assign i_end = ({1'b0, i_r} == m1);
  assign j_end = ({1'b0, j_r} == n1);
  assign r_end = ({1'b0, r_r} == k1);

  assign in_ready  = (state_r == mme_pkg::S_LOAD);
  assign cfg_ready = (state_r == mme_pkg::S_LOAD);
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    state_nxt  = state_r;
    a_rows_nxt = a_rows_r;
    inner_nxt  = inner_r;
    b_cols_nxt = b_cols_r;
    ph_b_nxt   = ph_b_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    r_nxt      = r_r;

    cmd           = '0;
    cmd.wr_right  = ph_b_r;
    cmd.wr_row    = ld_row_r;
    cmd.wr_col    = ld_col_r;
    cmd.rd_i      = i_r;
    cmd.rd_r      = r_r;
    cmd.rd_j      = j_r;
    cmd.mac_first = (r_r == '0);
    cmd.mac_last  = r_end;
    cmd.emit_row  = i_r;
    cmd.emit_col  = j_r;
    cmd.emit_last = i_end && j_end;

    unique case (state_r)
      mme_pkg::S_LOAD: begin
        cmd.wr_en = in_valid;
        if (in_valid) begin
          if ({1'b0, ld_col_r} == col_lim) begin
            ld_col_nxt = '0;
            if ({1'b0, ld_row_r} == row_lim) begin
              ld_row_nxt = '0;
              if (ph_b_r) begin
                ph_b_nxt  = 1'b0;
                i_nxt     = '0;
                j_nxt     = '0;
                r_nxt     = '0;
                state_nxt = mme_pkg::S_MAC;
              end else begin
                ph_b_nxt = 1'b1;
              end
            end else begin
              ld_row_nxt = ld_row_r + 1'b1;
            end
          end else begin
            ld_col_nxt = ld_col_r + 1'b1;
          end
        end
        if (cfg_wr) begin
          // any size write restarts loading
          unique case (cfg_index)
            mme_pkg::CFG_A_ROWS:     a_rows_nxt = clamp_dim(cfg_data);
            mme_pkg::CFG_INNER_SIZE: inner_nxt  = clamp_dim(cfg_data);
            mme_pkg::CFG_B_COLS:     b_cols_nxt = clamp_dim(cfg_data);
            default: ;
          endcase
          if (cfg_index != mme_pkg::CFG_SPARE) begin
            ph_b_nxt   = 1'b0;
            ld_row_nxt = '0;
            ld_col_nxt = '0;
          end
        end
      end
      mme_pkg::S_MAC: begin
        cmd.rd_en = 1'b1;
        if (r_end) begin
          r_nxt     = '0;
          state_nxt = mme_pkg::S_DRAIN;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      mme_pkg::S_DRAIN: begin
        if (sts.acc_done) state_nxt = mme_pkg::S_EMIT;
      end
      mme_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          if (j_end) begin
            j_nxt = '0;
            if (i_end) begin
              i_nxt     = '0;
              state_nxt = mme_pkg::S_LOAD;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = mme_pkg::S_MAC;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = mme_pkg::S_MAC;
          end
        end
      end
      default: state_nxt = mme_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mme_pkg::S_LOAD;
      a_rows_r <= mme_pkg::DIM_BITS'(1);
      inner_r  <= mme_pkg::DIM_BITS'(1);
      b_cols_r <= mme_pkg::DIM_BITS'(1);
      ph_b_r   <= 1'b0;
      ld_row_r <= '0;
      ld_col_r <= '0;
      i_r      <= '0;
      j_r      <= '0;
      r_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      a_rows_r <= a_rows_nxt;
      inner_r  <= inner_nxt;
      b_cols_r <= b_cols_nxt;
      ph_b_r   <= ph_b_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      r_r      <= r_nxt;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit issued while output register busy");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> ({1'b0, r_r} <= k1))
    else $error("inner index past inner_size");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.acc_done |-> (state_r == mme_pkg::S_DRAIN))
    else $error("accumulator finished outside drain");

  a_drain_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mme_pkg::S_DRAIN && sts.acc_done) |=> (state_r == mme_pkg::S_EMIT))
    else $error("finished sum not emitted");

endmodule

FILE: hw/rtl/mme_dp.sv
// Datapath of the matrix multiply engine: A and B stores, registered
// multiplier, accumulator, rounding/saturation and output register. Depends on mme_pkg.
module mme_dp #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [mme_pkg::ELEM_BITS-1:0] element,
  input  mme_pkg::dp_cmd_t                     cmd,
  output mme_pkg::dp_sts_t                     sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mme_pkg::IDX_BITS-1:0]         out_row,
  output logic [mme_pkg::IDX_BITS-1:0]         out_col,
  output logic signed [mme_pkg::ELEM_BITS-1:0] product_value,
  output logic                                 overflow,
  output logic                                 last
);

  localparam int unsigned EW    = (ELEMENT_WIDTH > mme_pkg::ELEM_BITS) ?
                                  mme_pkg::ELEM_BITS : ELEMENT_WIDTH;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W = 2 * EW + $clog2(MAX_DIM + 1);
  localparam int unsigned SH_W  = ACC_W - mme_pkg::FRAC_BITS;

  function automatic logic [IDX_W-1:0] addr_of(input mme_pkg::idx_t row,
                                               input mme_pkg::idx_t col);
    return IDX_W'(32'(row) * MAX_DIM + 32'(col));
  endfunction

  logic signed [EW-1:0]   left_mem  [DEPTH];
  logic signed [EW-1:0]   right_mem [DEPTH];

  logic signed [EW-1:0]   left_q_r, right_q_r;
  logic                   v1_r, first1_r, last1_r;
  logic signed [2*EW-1:0] prod_r;
  logic                   v2_r, first2_r, last2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                   done_r;

  logic                   out_valid_r;
  mme_pkg::idx_t          out_row_r, out_col_r;
  logic signed [mme_pkg::ELEM_BITS-1:0] value_r;
  logic                   ovf_r, last_r;

  logic signed [SH_W-1:0] shifted;
  logic [SH_W-EW:0]       top_bits;
  logic                   sat;
  logic signed [EW-1:0]   sat_val;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_right)
      left_mem[addr_of(cmd.wr_row, cmd.wr_col)] <= element[EW-1:0];
    if (cmd.wr_en && cmd.wr_right)
      right_mem[addr_of(cmd.wr_row, cmd.wr_col)] <= element[EW-1:0];
    if (cmd.rd_en) begin
      left_q_r  <= left_mem[addr_of(cmd.rd_i, cmd.rd_r)];
      right_q_r <= right_mem[addr_of(cmd.rd_r, cmd.rd_j)];
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.mac_first;
    last1_r  <= cmd.mac_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    if (v1_r) prod_r <= left_q_r * right_q_r;
    if (v2_r) acc_r <= first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= cmd.rd_en;
      v2_r   <= v1_r;
      done_r <= v2_r && last2_r;
    end
  end

  // floor to Q16.16 is an arithmetic shift; saturate when the dropped top
  // bits are not all copies of the sign
  assign shifted  = acc_r[ACC_W-1:mme_pkg::FRAC_BITS];
  assign top_bits = shifted[SH_W-1:EW-1];
  assign sat      = !((&top_bits) || !(|top_bits));
  always_comb begin
    if (!sat) sat_val = shifted[EW-1:0];
    else if (shifted[SH_W-1]) sat_val = {1'b1, {(EW-1){1'b0}}};
    else sat_val = {1'b0, {(EW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r <= cmd.emit_row;
      out_col_r <= cmd.emit_col;
      value_r   <= mme_pkg::ELEM_BITS'(sat_val);
      ovf_r     <= sat;
      last_r    <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.acc_done  = done_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign product_value = value_r;
  assign overflow      = ovf_r;
  assign last          = last_r;

endmodule

FILE: hw/rtl/matrix_multiply_engine_core.sv
// Load: one element per cycle, A (a_rows x inner_size) then B (inner_size x b_cols).
// After the last B element each product element is computed in turn: inner_size MAC
// issues through one multiplier of up to 32x32 bits, then the sum drains and is emitted.
// Results sit in an output register; the next A may load while the last waits.
// Reset (rst_n, synchronous, active low) sets all sizes to 1 and restarts
// loading; the element stores are not cleared.
module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  mme_elem_if.sink    in_elem,
  mme_prod_if.source  out_prod,
  mme_cfg_if.sink     cfg_wr
);

  mme_pkg::dp_cmd_t cmd;
  mme_pkg::dp_sts_t sts;

  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_elem.valid),
    .in_ready  (in_elem.ready),
    .cfg_valid (cfg_wr.valid),
    .cfg_ready (cfg_wr.ready),
    .cfg_index (cfg_wr.reg_index),
    .cfg_data  (cfg_wr.wr_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  mme_dp #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .element       (in_elem.element),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_prod.valid),
    .out_ready     (out_prod.ready),
    .out_row       (out_prod.out_row),
    .out_col       (out_prod.out_col),
    .product_value (out_prod.product_value),
    .overflow      (out_prod.overflow),
    .last          (out_prod.last)
  );

endmodule
